FILE: design/lcbs_pkg.sv
`timescale 1ns / 1ps
package lcbs_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int PATTERN_BITS = 16;
  localparam int POS_W        = $clog2(PATTERN_BITS);
  localparam int TICK_W       = 10;
  localparam int CFG_W        = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = 1;
  localparam int Q_CNT_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INVERT_OUTPUTS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_TOGGLE_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_TOGGLE_TICKS = 2'd2;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  localparam logic [TICK_W-1:0] SLOW_TICKS_RST = 10'd10;
  localparam logic [TICK_W-1:0] FAST_TICKS_RST = 10'd5;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_SLOW = 2'd2,
    MODE_FAST = 2'd3
  } mode_t;

  typedef logic [PATTERN_BITS-1:0] word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [TICK_W-1:0] advance_count(logic [TICK_W-1:0] count,
                                                      logic [TICK_W-1:0] period);
    logic [TICK_W-1:0] nxt;
    nxt = count + TICK_W'(1);
    if (nxt >= period || nxt == '0) begin
      nxt = '0;
    end
    return nxt;
  endfunction

endpackage

FILE: design/lcbs_front.sv
`timescale 1ns / 1ps
module lcbs_front import lcbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [3:0]           in_channel,
  input  logic [1:0]           in_mode,
  input  q_stat_t              q_stat,
  output logic                 push,
  output word_t                push_word
);

  logic              invert_r;
  logic [TICK_W-1:0] slow_ticks_r;
  logic [TICK_W-1:0] fast_ticks_r;
  logic [TICK_W-1:0] slow_cnt_r, slow_cnt_nxt;
  logic [TICK_W-1:0] fast_cnt_r, fast_cnt_nxt;
  logic              slow_ph_r, slow_ph_nxt;
  logic              fast_ph_r, fast_ph_nxt;
  mode_t             mode_r [NUM_CHANNELS];
  logic              accept;
  logic              set_acc;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (in_cmd == CMD_TICK);
  assign set_acc  = accept && (in_cmd == CMD_SET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r     <= 1'b0;
      slow_ticks_r <= SLOW_TICKS_RST;
      fast_ticks_r <= FAST_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INVERT_OUTPUTS:    invert_r     <= cfg_data[0];
        REG_SLOW_TOGGLE_TICKS: slow_ticks_r <= cfg_data[TICK_W-1:0];
        REG_FAST_TOGGLE_TICKS: fast_ticks_r <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // phases toggle on a zero count, before the counters advance
  always_comb begin
    slow_ph_nxt  = slow_ph_r ^ (slow_cnt_r == '0);
    fast_ph_nxt  = fast_ph_r ^ (fast_cnt_r == '0);
    slow_cnt_nxt = advance_count(slow_cnt_r, slow_ticks_r);
    fast_cnt_nxt = advance_count(fast_cnt_r, fast_ticks_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_cnt_r <= '0;
      fast_cnt_r <= '0;
      slow_ph_r  <= 1'b0;
      fast_ph_r  <= 1'b0;
    end else if (push) begin
      slow_cnt_r <= slow_cnt_nxt;
      fast_cnt_r <= fast_cnt_nxt;
      slow_ph_r  <= slow_ph_nxt;
      fast_ph_r  <= fast_ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        mode_r[i] <= MODE_OFF;
      end
    end else if (set_acc) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (32'(in_channel) == i) begin
          mode_r[i] <= mode_t'(in_mode);
        end
      end
    end
  end

  always_comb begin
    push_word = '0;
    for (int i = 0; i < NUM_CHANNELS && i < PATTERN_BITS; i++) begin
      case (mode_r[i])
        MODE_ON:   push_word[i] = 1'b1;
        MODE_SLOW: push_word[i] = slow_ph_nxt;
        MODE_FAST: push_word[i] = fast_ph_nxt;
        default:   push_word[i] = 1'b0;
      endcase
    end
    if (invert_r) begin
      push_word = ~push_word;
    end
  end

endmodule

FILE: design/lcbs_queue.sv
`timescale 1ns / 1ps
module lcbs_queue import lcbs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  word_t   push_word,
  input  logic    pop,
  output word_t   head_word,
  output q_stat_t q_stat
);

  word_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_push;
  logic               do_pop;

  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_word    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + Q_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - Q_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: design/lcbs_back.sv
`timescale 1ns / 1ps
module lcbs_back import lcbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  q_stat_t          q_stat,
  input  word_t            head_word,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_serial_data,
  output logic [3:0]       out_bit_index,
  output logic             out_latch,
  output logic [15:0]      out_pattern
);

  logic             busy_r, busy_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  word_t            word_r, word_nxt;
  logic             take;
  logic             last;

  assign take = busy_r && !out_stall;
  assign last = (pos_r == '0);

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    word_nxt = word_r;
    pop      = 1'b0;
    if (!busy_r || (take && last)) begin
      // load the next word straight behind the last bit, no gap
      if (!q_stat.empty) begin
        pop      = 1'b1;
        busy_nxt = 1'b1;
        pos_nxt  = POS_W'(PATTERN_BITS - 1);
        word_nxt = head_word;
      end else begin
        busy_nxt = 1'b0;
      end
    end else if (take) begin
      pos_nxt = pos_r - POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_valid       = busy_r;
  assign out_serial_data = word_r[pos_r];
  assign out_bit_index   = 4'(pos_r);
  assign out_latch       = last;
  assign out_pattern     = 16'(word_r);

endmodule

FILE: design/led_channel_blinker_serializer_unit.sv
`timescale 1ns / 1ps
// channel   direction  ports
// in_       input      in_valid / in_stall : cmd, channel, mode
// out_      output     out_valid / out_stall : serial_data, bit_index, latch, pattern
// cfg_      input      cfg_we : cfg_index, cfg_data (no read-back)
//
// A set transaction gives no result. A tick transaction passes through the front and
// yields 16 results from the serializer, one per cycle while out_stall is low.
// Sustained tick rate is set by the serializer, which shifts one bit per cycle unless stalled;
// a two-word queue lets the front keep accepting while the back shifts.
// Reset (rst_n low, synchronous) clears modes, counters, phases and the queue.
// in_stall is high while the queue is full; out_stall holds the current bit.
module led_channel_blinker_serializer_unit import lcbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [3:0]           in_channel,
  input  logic [1:0]           in_mode,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_serial_data,
  output logic [3:0]           out_bit_index,
  output logic                 out_latch,
  output logic [15:0]          out_pattern
);

  q_stat_t q_stat;
  logic    push;
  word_t   push_word;
  logic    pop;
  word_t   head_word;

  lcbs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_channel (in_channel),
    .in_mode    (in_mode),
    .q_stat     (q_stat),
    .push       (push),
    .push_word  (push_word)
  );

  lcbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head_word (head_word),
    .q_stat    (q_stat)
  );

  lcbs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head_word       (head_word),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_serial_data (out_serial_data),
    .out_bit_index   (out_bit_index),
    .out_latch       (out_latch),
    .out_pattern     (out_pattern)
  );

endmodule
